@@ design/atrs_pkg.sv @@
// Package: character and token types, response suffix table and suffix match function.
package atrs_pkg;

    localparam int WINDOW_CHARS_DEFAULT = 16;
    localparam int TAIL_CHARS           = 16;
    localparam int SUFFIX_COUNT         = 9;
    localparam int CHAR_BITS            = 7;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef char_t [TAIL_CHARS-1:0] tail_t;
    typedef logic [3:0] token_t;

    localparam token_t TOKEN_NONE      = 4'd0;
    localparam token_t TOKEN_READY     = 4'd1;
    localparam token_t TOKEN_CLOSED    = 4'd2;
    localparam token_t TOKEN_SEND_OK   = 4'd3;
    localparam token_t TOKEN_OK        = 4'd4;
    localparam token_t TOKEN_IPD       = 4'd5;
    localparam token_t TOKEN_BUSY      = 4'd6;
    localparam token_t TOKEN_GOT_IP    = 4'd7;
    localparam token_t TOKEN_CONNECTED = 4'd8;
    localparam token_t TOKEN_ERROR     = 4'd9;

    typedef struct packed {
        logic   accepted;
        token_t token;
    } result_t;

    localparam logic [8*TAIL_CHARS-1:0] SUFFIX_STR [SUFFIX_COUNT] = '{
        "ready",
        "CLOSED\r\n",
        "SEND OK\r\n",
        "OK\r\n",
        "+IPD,",
        "busy s...\r\n",
        "WIFI GOT IP\r\n",
        "WIFI CONNECTED\r\n",
        "ERROR\r\n"
    };

    localparam int SUFFIX_LEN [SUFFIX_COUNT] = '{5, 8, 9, 4, 5, 11, 13, 16, 7};

    // tail[0] is the newest character; lowest suffix index wins
    function automatic token_t match_token(tail_t tail);
        token_t tok;
        logic   hit;
        tok = TOKEN_NONE;
        for (int k = SUFFIX_COUNT - 1; k >= 0; k--)
        begin
            hit = 1'b1;
            for (int i = 0; i < TAIL_CHARS; i++)
            begin
                if (i < SUFFIX_LEN[k] && tail[i] != SUFFIX_STR[k][8*i +: CHAR_BITS])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                tok = token_t'(k + 1);
            end
        end
        return tok;
    endfunction

endpackage

@@ design/at_response_suffix_recognizer.sv @@
// Top level: modem response suffix recognizer with input and result registers.
//
// One received byte per input beat, one result beat per input beat, in order. The block
// takes a new byte every cycle while the result side keeps up; an accepted byte passes
// from the input register to the result register. The whole window shift and the parallel
// compare against all nine suffixes sit in the combinational logic between the input
// register and the result register. Bytes that are zero or have bit 7 set leave the window
// unchanged and return token 0 with accepted low.
module at_response_suffix_recognizer #(
    parameter int WINDOW_CHARS = atrs_pkg::WINDOW_CHARS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] token, [4] accepted, [7:5] zero
);

    typedef atrs_pkg::char_t [WINDOW_CHARS-1:0] window_t;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    atrs_pkg::result_t result_reg;
    atrs_pkg::result_t result_next;
    window_t           window_reg;
    window_t           window_next;
    logic              advance;
    logic              pass;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign pass     = (in_byte_reg != 8'd0) && !in_byte_reg[7];

    always_comb
    begin
        window_next = window_reg;
        if (pass)
        begin
            window_next = {window_reg[WINDOW_CHARS-2:0],
                           in_byte_reg[atrs_pkg::CHAR_BITS-1:0]};
        end
        result_next.accepted = pass;
        result_next.token    = pass
            ? atrs_pkg::match_token(window_next[atrs_pkg::TAIL_CHARS-1:0])
            : atrs_pkg::TOKEN_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (in_valid_reg && advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg};

    a_token_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] != atrs_pkg::TOKEN_NONE) |-> m_tdata[4])
        else $error("token reported for a dropped byte");

    a_token_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= atrs_pkg::TOKEN_ERROR))
        else $error("token code out of range");

    a_drop_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && !pass |=> $stable(window_reg))
        else $error("dropped byte changed the window");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule
